FILE: rtl/core/smhc_pkg.sv
// ----------------------------------------------------------------------------
// smhc_pkg - shared types and widths for the stress Hessian cell unit
// Field widths of the item ports and of the per-row accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

package smhc_pkg;

	// item field widths
	localparam int FIELD_W = 31;   // weight, dissimilarity, distance (unsigned)
	localparam int COORD_W = 32;   // coordinates, V and B entries (signed)
	localparam int DIFF_W  = 33;   // coordinate difference, v - b
	localparam int ABS_W   = 32;   // magnitude of a coordinate difference

	// per-row state
	localparam int SUM_W  = 48;    // saturating row sum
	localparam int CORR_W = 33;    // diagonal correction v - b

	typedef logic [FIELD_W-1:0]        field_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [CORR_W-1:0]  corr_t;

endpackage

`default_nettype wire

FILE: rtl/core/smhc_ser_mul.sv
// ----------------------------------------------------------------------------
// smhc_ser_mul - bit-serial unsigned multiplier
// Shift-add over the bits of b, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smhc_ser_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             busy,
	output logic [AW+BW-1:0] prod
);

	localparam int CNT_W = $clog2(BW + 1);

	logic [AW-1:0]    a_q;
	logic [AW-1:0]    hi_q;
	logic [BW-1:0]    lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [AW:0]      sum_c;

	// partial product add for the current multiplier bit
	assign sum_c = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(AW+1){1'b0}});

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(BW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// product shift register: high half accumulates, low half shifts out b
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum_c[AW:1];
			lo_q <= {sum_c[0], lo_q[BW-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = {hi_q, lo_q};

endmodule

`default_nettype wire

FILE: rtl/core/smhc_ser_div.sv
// ----------------------------------------------------------------------------
// smhc_ser_div - restoring serial divider with early overflow check
// Produces QW quotient bits, one per cycle; flags a quotient that needs more than QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module smhc_ser_div #(
	parameter int NW = 126,
	parameter int DW = 93,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic          ovf,
	output logic [QW-1:0] quo
);

	localparam int HW    = NW - QW;
	localparam int CW    = (HW > DW) ? HW : DW;
	localparam int CNT_W = $clog2(QW + 1);

	logic [CW-1:0]    hi_ext;
	logic [CW-1:0]    den_ext;
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    rem_q;
	logic [QW-1:0]    nq_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DW:0]      trial_c;
	logic [DW:0]      diff_c;
	logic             ge_c;

	// quotient fits QW bits only when the upper numerator is below the divisor
	assign hi_ext  = CW'(num[NW-1:QW]);
	assign den_ext = CW'(den);

	// one restoring step
	assign trial_c = {rem_q, nq_q[QW-1]};
	assign diff_c  = trial_c - {1'b0, den_q};
	assign ge_c    = (trial_c >= {1'b0, den_q});

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and numerator/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= (hi_ext >= den_ext);
			den_q <= den;
			rem_q <= hi_ext[DW-1:0];
			nq_q  <= num[QW-1:0];
		end else if (busy_q) begin
			rem_q <= ge_c ? diff_c[DW-1:0] : trial_c[DW-1:0];
			nq_q  <= {nq_q[QW-2:0], ge_c};
		end
	end

	assign busy = busy_q;
	assign ovf  = ovf_q;
	assign quo  = nq_q;

endmodule

`default_nettype wire

FILE: rtl/core/mds_stress_hessian_cell_unit.sv
// ----------------------------------------------------------------------------
// mds_stress_hessian_cell_unit - one row of a stress Hessian block, streamed
// Off-diagonal item: three serial first products, the 62-bit serial numerator
//   multiply with the cubed-distance multiply, then the bit-a-cycle divide; the
//   input stays stalled until the result is loaded into the output register.
// Diagonal item: taken without stalling unless it ends the row; the diagonal
//   result is loaded in the DIAG state, after EMIT of a last off-diagonal item.
// Reset clears the row sum, the correction and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mds_stress_hessian_cell_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  smhc_pkg::field_t              weight,
	input  smhc_pkg::field_t              dissimilarity,
	input  smhc_pkg::field_t              distance,
	input  smhc_pkg::coord_t              row_coord_s,
	input  smhc_pkg::coord_t              col_coord_s,
	input  smhc_pkg::coord_t              row_coord_t,
	input  smhc_pkg::coord_t              col_coord_t,
	input  smhc_pkg::coord_t              v_entry,
	input  smhc_pkg::coord_t              b_entry,
	input  logic                          same_block,
	input  logic                          on_diagonal,
	input  logic                          last_in_row,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] value,
	output logic                          is_diagonal,
	output logic                          row_done
);

	import smhc_pkg::*;

	// product widths
	localparam int WD_W  = 2 * FIELD_W;
	localparam int ST_W  = 2 * ABS_W;
	localparam int NUM_W = WD_W + ST_W;
	localparam int DD_W  = 2 * FIELD_W;
	localparam int DEN_W = DD_W + FIELD_W;
	localparam int EXT_W = ((VALUE_WIDTH > SUM_W) ? VALUE_WIDTH : SUM_W) + 2;
	localparam int SE_W  = SUM_W + 1;

	localparam logic signed [EXT_W-1:0] VMAX_E =
		{{(EXT_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [EXT_W-1:0] VMIN_E = ~VMAX_E;
	localparam logic signed [SE_W-1:0]  SMAX_E = {2'b00, {(SUM_W-1){1'b1}}};
	localparam logic signed [SE_W-1:0]  SMIN_E = ~SMAX_E;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;
	localparam logic [2:0] ST_DIAG = 3'd5;

	function automatic logic signed [VALUE_WIDTH-1:0] sat_val(
		input logic signed [EXT_W-1:0] x
	);
		if (x > VMAX_E) begin
			return VMAX_E[VALUE_WIDTH-1:0];
		end else if (x < VMIN_E) begin
			return VMIN_E[VALUE_WIDTH-1:0];
		end
		return x[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] neg_c_sel(input logic neg);
		return neg ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	endfunction

	logic [2:0] state_q;
	logic       in_acc;
	logic       out_free;

	logic signed [DIFF_W-1:0] s_diff_c, t_diff_c, vb_c;
	logic [ABS_W-1:0]         s_abs_c, t_abs_c;
	logic                     neg_c;

	logic                     neg_q;
	logic                     last_q;
	field_t                   d_q;
	corr_t                    vb_q;
	sum_t                     row_sum_q;
	corr_t                    corr_q;
	logic signed [VALUE_WIDTH-1:0] cell_q;

	logic             start1, start2, start3;
	logic             busy_wd, busy_st, busy_dd, busy_num, busy_den, busy_div;
	logic [WD_W-1:0]  p_wd;
	logic [ST_W-1:0]  p_st;
	logic [DD_W-1:0]  p_dd;
	logic [NUM_W-1:0] p_num;
	logic [DEN_W-1:0] p_den;
	logic             div_ovf;
	logic [VALUE_WIDTH-1:0] div_q;

	logic [VALUE_WIDTH-1:0]        cap_c, mag_c;
	logic signed [VALUE_WIDTH-1:0] cell_c;
	logic signed [EXT_W-1:0]       off_e, diag_e;
	logic signed [SE_W-1:0]        sum_e;
	sum_t                          sum_sat_c;

	logic                          out_valid_q;
	logic signed [VALUE_WIDTH-1:0] value_q;
	logic                          is_diag_q;
	logic                          row_done_q;
	logic                          load_off, load_diag;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// coordinate differences, magnitudes and sign of the cell
	assign s_diff_c = DIFF_W'(row_coord_s) - DIFF_W'(col_coord_s);
	assign t_diff_c = DIFF_W'(row_coord_t) - DIFF_W'(col_coord_t);
	assign vb_c     = DIFF_W'(v_entry) - DIFF_W'(b_entry);
	assign s_abs_c  = s_diff_c[DIFF_W-1] ? ABS_W'(-s_diff_c) : s_diff_c[ABS_W-1:0];
	assign t_abs_c  = t_diff_c[DIFF_W-1] ? ABS_W'(-t_diff_c) : t_diff_c[ABS_W-1:0];
	assign neg_c    = (s_diff_c != '0) && (t_diff_c != '0)
		&& (s_diff_c[DIFF_W-1] ^ t_diff_c[DIFF_W-1]);

	// stage starts
	assign start1 = in_acc && !on_diagonal;
	assign start2 = (state_q == ST_MUL1) && !(busy_wd || busy_st || busy_dd);
	assign start3 = (state_q == ST_MUL2) && !(busy_num || busy_den);

	// first products: w*delta, |s|*|t|, d*d
	smhc_ser_mul #(.AW(FIELD_W), .BW(FIELD_W)) u_mul_wd (
		.clk, .arst_n, .start(start1), .a(weight), .b(dissimilarity),
		.busy(busy_wd), .prod(p_wd)
	);
	smhc_ser_mul #(.AW(ABS_W), .BW(ABS_W)) u_mul_st (
		.clk, .arst_n, .start(start1), .a(s_abs_c), .b(t_abs_c),
		.busy(busy_st), .prod(p_st)
	);
	smhc_ser_mul #(.AW(FIELD_W), .BW(FIELD_W)) u_mul_dd (
		.clk, .arst_n, .start(start1), .a(distance), .b(distance),
		.busy(busy_dd), .prod(p_dd)
	);

	// numerator and cubed distance
	smhc_ser_mul #(.AW(ST_W), .BW(WD_W)) u_mul_num (
		.clk, .arst_n, .start(start2), .a(p_st), .b(p_wd),
		.busy(busy_num), .prod(p_num)
	);
	smhc_ser_mul #(.AW(DD_W), .BW(FIELD_W)) u_mul_den (
		.clk, .arst_n, .start(start2), .a(p_dd), .b(d_q),
		.busy(busy_den), .prod(p_den)
	);

	// quotient; a zero distance always shows as overflow
	smhc_ser_div #(.NW(NUM_W), .DW(DEN_W), .QW(VALUE_WIDTH)) u_div (
		.clk, .arst_n, .start(start3), .num(p_num), .den(p_den),
		.busy(busy_div), .ovf(div_ovf), .quo(div_q)
	);

	// saturated signed cell
	assign cap_c  = neg_c_sel(neg_q);
	assign mag_c  = (div_ovf || (div_q > cap_c)) ? cap_c : div_q;
	assign cell_c = neg_q ? -$signed(mag_c) : $signed(mag_c);

	// result values and row sum update
	assign off_e  = EXT_W'(vb_q) - EXT_W'(cell_q);
	assign diag_e = EXT_W'(row_sum_q) + EXT_W'(corr_q);
	assign sum_e  = SE_W'(row_sum_q) + SE_W'(cell_q);
	assign sum_sat_c = (sum_e > SMAX_E) ? SMAX_E[SUM_W-1:0] :
		((sum_e < SMIN_E) ? SMIN_E[SUM_W-1:0] : sum_e[SUM_W-1:0]);

	assign load_off  = (state_q == ST_EMIT) && out_free;
	assign load_diag = (state_q == ST_DIAG) && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!on_diagonal) begin
							state_q <= ST_MUL1;
						end else if (last_in_row) begin
							state_q <= ST_DIAG;
						end
					end
				end
				ST_MUL1: begin
					if (start2) begin
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					if (start3) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!busy_div) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= last_q ? ST_DIAG : ST_IDLE;
					end
				end
				ST_DIAG: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// row state: sum of cells and diagonal correction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
			corr_q    <= '0;
		end else if (load_diag) begin
			row_sum_q <= '0;
			corr_q    <= '0;
		end else begin
			if (in_acc && on_diagonal) begin
				corr_q <= same_block ? vb_c : '0;
			end
			if (load_off) begin
				row_sum_q <= sum_sat_c;
			end
		end
	end

	// item capture and cell register
	always_ff @(posedge clk) begin
		if (start1) begin
			neg_q  <= neg_c;
			last_q <= last_in_row;
			d_q    <= distance;
			vb_q   <= same_block ? vb_c : '0;
		end
		if ((state_q == ST_DIV) && !busy_div) begin
			cell_q <= cell_c;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_off || load_diag) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_off) begin
			value_q    <= sat_val(off_e);
			is_diag_q  <= 1'b0;
			row_done_q <= 1'b0;
		end else if (load_diag) begin
			value_q    <= sat_val(diag_e);
			is_diag_q  <= 1'b1;
			row_done_q <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign is_diagonal = is_diag_q;
	assign row_done    = row_done_q;

endmodule

`default_nettype wire

FILE: rtl/core/smhc_checker.sv
// ----------------------------------------------------------------------------
// smhc_checker - port-level checks for the stress Hessian cell unit
// Result flags, output hold under stall and input acceptance pacing.
// ----------------------------------------------------------------------------
`default_nettype none

module smhc_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          on_diagonal,
	input logic                          last_in_row,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [VALUE_WIDTH-1:0] value,
	input logic                          is_diagonal,
	input logic                          row_done
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value)
			&& $stable(is_diagonal) && $stable(row_done))
		else $error("result item changed under stall");

	// only the diagonal result closes a row, and it always does
	a_done_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (row_done == is_diagonal))
		else $error("row_done and is_diagonal disagree");

	// an off-diagonal item keeps the unit busy
	a_busy_after_off: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !on_diagonal |=> in_stall)
		else $error("input taken while an item is in work");

	// a diagonal item that does not end the row leaves the input free
	a_diag_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && on_diagonal && !last_in_row |=> !in_stall)
		else $error("diagonal item held the input");

endmodule

bind mds_stress_hessian_cell_unit smhc_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_smhc_checker (.*);

`default_nettype wire

FILE: test/mds_stress_hessian_cell_unit_tb.sv
// ----------------------------------------------------------------------------
// mds_stress_hessian_cell_unit_tb - self-checking bench for the Hessian row unit
// Streams rows of pair items through the unit and checks each Hessian entry
// against a bit-true predictor: the cell quotient, the saturation rules and
// the row sum with its diagonal correction. Directed corner rows come first,
// then random rows under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module mds_stress_hessian_cell_unit_tb;

	import smhc_pkg::*;

	localparam int VW = 32;
	localparam int OP_CYCLES = VW + 98;
	localparam int CYCLE_LIMIT = 2_000_000;

	localparam longint VAL_MAX = (64'sd1 <<< (VW - 1)) - 1;
	localparam longint VAL_MIN = -VAL_MAX - 1;
	localparam longint SUM_MAX = (64'sd1 <<< (SUM_W - 1)) - 1;
	localparam longint SUM_MIN = -SUM_MAX - 1;

	localparam field_t F_MAX = '1;
	localparam field_t F_ONE = 31'h0001_0000;
	localparam coord_t C_MAX = 32'sh7FFF_FFFF;
	localparam coord_t C_MIN = 32'sh8000_0000;
	localparam coord_t C_ONE = 32'sh0001_0000;

	typedef struct {
		field_t weight;
		field_t dissimilarity;
		field_t distance;
		coord_t row_coord_s;
		coord_t col_coord_s;
		coord_t row_coord_t;
		coord_t col_coord_t;
		coord_t v_entry;
		coord_t b_entry;
		logic   same_block;
		logic   on_diagonal;
		logic   last_in_row;
	} pair_item_t;

	typedef struct {
		logic signed [VW-1:0] entry;
		logic                 diag_flag;
		logic                 done_flag;
	} hessian_entry_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	field_t weight;
	field_t dissimilarity;
	field_t distance;
	coord_t row_coord_s;
	coord_t col_coord_s;
	coord_t row_coord_t;
	coord_t col_coord_t;
	coord_t v_entry;
	coord_t b_entry;
	logic same_block;
	logic on_diagonal;
	logic last_in_row;
	logic out_valid;
	logic out_stall;
	logic signed [VW-1:0] value;
	logic is_diagonal;
	logic row_done;

	hessian_entry_t hessian_expected[$];
	longint row_acc;
	longint diag_corr;
	int errors = 0;
	int items_sent;
	int send_idle_pct;
	int recv_idle_pct;
	int cycle_count = 0;

	mds_stress_hessian_cell_unit #(
		.VALUE_WIDTH(VW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.weight(weight),
		.dissimilarity(dissimilarity),
		.distance(distance),
		.row_coord_s(row_coord_s),
		.col_coord_s(col_coord_s),
		.row_coord_t(row_coord_t),
		.col_coord_t(col_coord_t),
		.v_entry(v_entry),
		.b_entry(b_entry),
		.same_block(same_block),
		.on_diagonal(on_diagonal),
		.last_in_row(last_in_row),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.is_diagonal(is_diagonal),
		.row_done(row_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("mds_stress_hessian_cell_unit: mismatch");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic longint sat(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// expected entries for one accepted item; updates the row state
	function automatic void predict_hessian(input pair_item_t it);
		longint s, t, vb, cell_v, v;
		logic [63:0] as_, at_, cap, mag;
		logic [127:0] num, den, quo;
		bit neg;
		s = longint'(it.row_coord_s) - longint'(it.col_coord_s);
		t = longint'(it.row_coord_t) - longint'(it.col_coord_t);
		vb = longint'(it.v_entry) - longint'(it.b_entry);
		if (it.on_diagonal) begin
			diag_corr = it.same_block ? vb : 0;
		end else begin
			neg = (s != 0 && t != 0) && ((s < 0) != (t < 0));
			as_ = (s < 0) ? -s : s;
			at_ = (t < 0) ? -t : t;
			cap = neg ? VAL_MAX + 1 : VAL_MAX;
			// zero distance saturates to the signed limit
			if (it.distance == 0) begin
				mag = cap;
			end else begin
				num = 128'(it.weight) * 128'(it.dissimilarity) * 128'(as_) * 128'(at_);
				den = 128'(it.distance) * 128'(it.distance) * 128'(it.distance);
				quo = num / den;
				mag = (quo > 128'(cap)) ? cap : quo[63:0];
			end
			cell_v = neg ? -longint'(mag) : longint'(mag);
			v = sat(-cell_v + (it.same_block ? vb : 0), VAL_MIN, VAL_MAX);
			row_acc = sat(row_acc + cell_v, SUM_MIN, SUM_MAX);
			hessian_expected.push_back('{entry: v[VW-1:0], diag_flag: 1'b0, done_flag: 1'b0});
		end
		// row close: diagonal entry, then clear the row state
		if (it.last_in_row) begin
			v = sat(row_acc + diag_corr, VAL_MIN, VAL_MAX);
			hessian_expected.push_back('{entry: v[VW-1:0], diag_flag: 1'b1, done_flag: 1'b1});
			row_acc = 0;
			diag_corr = 0;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		hessian_entry_t exp_e;
		if (arst_n && out_valid && !out_stall) begin
			if (hessian_expected.size() == 0) begin
				$display("%0t: unexpected item: value %0d is_diagonal %0b row_done %0b",
					$time, value, is_diagonal, row_done);
				errors++;
			end else begin
				exp_e = hessian_expected.pop_front();
				if (value !== exp_e.entry) begin
					$display("%0t: value expected %0d got %0d", $time, exp_e.entry, value);
					errors++;
				end
				if (is_diagonal !== exp_e.diag_flag) begin
					$display("%0t: is_diagonal expected %0b got %0b",
						$time, exp_e.diag_flag, is_diagonal);
					errors++;
				end
				if (row_done !== exp_e.done_flag) begin
					$display("%0t: row_done expected %0b got %0b",
						$time, exp_e.done_flag, row_done);
					errors++;
				end
			end
		end
	end

	function automatic pair_item_t make_item(input field_t w, input field_t dl, input field_t d,
		input coord_t rs, input coord_t cs, input coord_t rt, input coord_t ct,
		input coord_t vv, input coord_t bb, input logic same, input logic diag,
		input logic last);
		pair_item_t it;
		it.weight = w;
		it.dissimilarity = dl;
		it.distance = d;
		it.row_coord_s = rs;
		it.col_coord_s = cs;
		it.row_coord_t = rt;
		it.col_coord_t = ct;
		it.v_entry = vv;
		it.b_entry = bb;
		it.same_block = same;
		it.on_diagonal = diag;
		it.last_in_row = last;
		return it;
	endfunction

	// hand one item to the unit, with random idle cycles ahead of it
	task automatic send_item(input pair_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		weight <= it.weight;
		dissimilarity <= it.dissimilarity;
		distance <= it.distance;
		row_coord_s <= it.row_coord_s;
		col_coord_s <= it.col_coord_s;
		row_coord_t <= it.row_coord_t;
		col_coord_t <= it.col_coord_t;
		v_entry <= it.v_entry;
		b_entry <= it.b_entry;
		same_block <= it.same_block;
		on_diagonal <= it.on_diagonal;
		last_in_row <= it.last_in_row;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_hessian(it);
		items_sent++;
	endtask

	// unsigned fields: mostly near one, with zeros, maxima and full-range values
	function automatic field_t pick_field();
		case ($urandom_range(9))
			0: return '0;
			1: return F_MAX;
			2, 3: return field_t'($urandom);
			default: return field_t'($urandom_range(1 << 19, 1 << 12));
		endcase
	endfunction

	function automatic coord_t pick_coord();
		case ($urandom_range(9))
			0: return C_MIN;
			1: return C_MAX;
			2, 3: return coord_t'($urandom);
			default: return coord_t'($urandom_range(1 << 19, 0)) - (1 << 18);
		endcase
	endfunction

	// one row: mostly one diagonal item, sometimes none or a repeated one
	task automatic send_random_row(input int n_cols);
		pair_item_t it;
		int diag_pos, dup_pos, shape;
		logic same;
		diag_pos = $urandom_range(n_cols - 1);
		dup_pos = $urandom_range(n_cols - 1);
		shape = $urandom_range(9);
		same = 1'($urandom_range(1));
		for (int c = 0; c < n_cols; c++) begin
			it = make_item(pick_field(), pick_field(), pick_field(), pick_coord(),
				pick_coord(), pick_coord(), pick_coord(), coord_t'($urandom),
				coord_t'($urandom), ($urandom_range(19) == 0) ? ~same : same,
				(shape != 0 && c == diag_pos) || (shape == 1 && c == dup_pos),
				c == n_cols - 1);
			send_item(it);
		end
	endtask

	// field extremes, unity values, diagonal mid-row, off-diagonal last item
	task automatic test_field_extremes();
		send_item(make_item(F_MAX, F_MAX, F_ONE, C_MAX, C_MIN, C_MIN, C_MAX, 0, 0,
			1'b1, 1'b0, 1'b0));
		send_item(make_item('0, F_MAX, 31'd1, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN,
			1'b0, 1'b0, 1'b0));
		send_item(make_item(F_ONE, F_ONE, F_MAX, C_ONE, 0, C_ONE, 0, 0, 0,
			1'b1, 1'b0, 1'b0));
		send_item(make_item(F_ONE, F_ONE, F_ONE, 2 * C_ONE, C_ONE, 3 * C_ONE, 0,
			C_MAX, C_MIN, 1'b1, 1'b0, 1'b0));
		send_item(make_item(F_ONE, F_ONE, F_ONE, 0, 0, 0, 0, C_ONE, -C_ONE,
			1'b1, 1'b1, 1'b0));
		send_item(make_item(F_ONE, F_ONE, F_ONE << 1, -C_ONE, C_ONE, C_ONE, 0, C_ONE, 0,
			1'b1, 1'b0, 1'b1));
	endtask

	// zero distance: opposite-sign, equal-sign and zero differences, and a diagonal item
	task automatic test_zero_distance();
		send_item(make_item(F_ONE, F_ONE, '0, C_ONE, 0, -C_ONE, 0, 0, 0,
			1'b0, 1'b0, 1'b0));
		send_item(make_item(F_ONE, F_ONE, '0, C_ONE, C_ONE, -C_ONE, 0, 0, 0,
			1'b0, 1'b0, 1'b0));
		send_item(make_item(F_ONE, F_ONE, '0, C_ONE, 0, C_ONE, C_ONE, 0, 0,
			1'b0, 1'b0, 1'b0));
		send_item(make_item(F_ONE, F_ONE, '0, C_MIN, 0, C_MIN, 0, C_MAX, C_MIN,
			1'b0, 1'b1, 1'b0));
		send_item(make_item(F_ONE, F_ONE, '0, -C_ONE, 0, -C_ONE, 0, 0, 0,
			1'b0, 1'b0, 1'b1));
	endtask

	// diagonal bookkeeping and output saturation
	task automatic test_diagonal_rows();
		// repeated diagonal: the second one wins
		send_item(make_item(F_ONE, F_ONE, F_ONE, 0, 0, 0, 0, C_MAX, C_MIN,
			1'b1, 1'b1, 1'b0));
		send_item(make_item(F_ONE, F_ONE, F_ONE, 0, 0, 0, 0, -C_ONE, C_ONE,
			1'b1, 1'b1, 1'b0));
		send_item(make_item(F_ONE, F_ONE << 1, F_ONE, C_ONE, 0, C_ONE, 0, 0, 0,
			1'b1, 1'b0, 1'b1));
		// row that is a lone diagonal item
		send_item(make_item(F_MAX, F_MAX, '0, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX,
			1'b1, 1'b1, 1'b1));
		// row without a diagonal item
		send_item(make_item(F_ONE, F_ONE, F_ONE, 3 * C_ONE, 0, C_ONE, 0, C_ONE, 0,
			1'b1, 1'b0, 1'b0));
		send_item(make_item(F_ONE, F_ONE, F_ONE, C_ONE, 0, -C_ONE, 0, 0, C_ONE,
			1'b0, 1'b0, 1'b1));
		// diagonal as the last item after an off-diagonal one
		send_item(make_item(F_ONE, F_ONE, F_ONE, 2 * C_ONE, 0, 2 * C_ONE, 0, 0, 0,
			1'b0, 1'b0, 1'b0));
		send_item(make_item(F_ONE, F_ONE, F_ONE, 0, 0, 0, 0, 5 * C_ONE, C_ONE,
			1'b1, 1'b1, 1'b1));
		// negative output saturation: large positive cell and v - b at its minimum
		send_item(make_item(F_ONE, F_ONE, '0, C_ONE, 0, C_ONE, 0, C_MIN, C_MAX,
			1'b1, 1'b0, 1'b1));
	endtask

	// random rows under one idling mix
	task automatic test_random_rows(input int send_pct, input int recv_pct, input int n_items);
		int stop_at;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			send_random_row(($urandom_range(9) == 0) ? $urandom_range(12, 1) :
				$urandom_range(6, 1));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		weight <= '0;
		dissimilarity <= '0;
		distance <= '0;
		row_coord_s <= '0;
		col_coord_s <= '0;
		row_coord_t <= '0;
		col_coord_t <= '0;
		v_entry <= '0;
		b_entry <= '0;
		same_block <= 1'b0;
		on_diagonal <= 1'b0;
		last_in_row <= 1'b0;
		items_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		row_acc = 0;
		diag_corr = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_zero_distance();
		test_diagonal_rows();
		test_random_rows(0, 0, 375);
		test_random_rows(54, 0, 375);
		test_random_rows(0, 54, 375);
		test_random_rows(31, 31, 375);
		in_valid <= 1'b0;

		// drain, then give the unit time for anything unexpected
		while (hessian_expected.size() != 0) @(posedge clk);
		repeat (2 * OP_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("mds_stress_hessian_cell_unit: match");
		end else begin
			$display("mds_stress_hessian_cell_unit: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
